// ----- hw/rtl/multi_policy_task_scheduler_assert.svh -----
// Assertion macros used by the scheduler engine.
`ifndef MULTI_POLICY_TASK_SCHEDULER_ASSERT_SVH
`define MULTI_POLICY_TASK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MPTS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is high.
`define MPTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

// ----- hw/rtl/mpts_pkg.sv -----
`default_nettype none
package mpts_pkg;

   // Number of task table entries; entry fields are six bits wide.
   localparam int NUM_ENTRIES = 64;

   // Operation codes of a request beat.
   localparam logic [2:0] OP_ALLOC     = 3'd0;
   localparam logic [2:0] OP_SET_STATE = 3'd1;
   localparam logic [2:0] OP_SET_PRIO  = 3'd2;
   localparam logic [2:0] OP_TICK      = 3'd3;
   localparam logic [2:0] OP_PICK      = 3'd4;
   localparam logic [2:0] OP_QUERY     = 3'd5;

   // Entry states.
   localparam logic [2:0] ST_UNUSED   = 3'd0;
   localparam logic [2:0] ST_EMBRYO   = 3'd1;
   localparam logic [2:0] ST_SLEEPING = 3'd2;
   localparam logic [2:0] ST_RUNNABLE = 3'd3;
   localparam logic [2:0] ST_RUNNING  = 3'd4;
   localparam logic [2:0] ST_ZOMBIE   = 3'd5;

   // Pick strategies.
   localparam logic [2:0] STRAT_RR       = 3'd0;
   localparam logic [2:0] STRAT_RR_QUANT = 3'd1;
   localparam logic [2:0] STRAT_PRIO_Q   = 3'd2;
   localparam logic [2:0] STRAT_PRIO_TBL = 3'd3;
   localparam logic [2:0] STRAT_LOTTERY  = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_STRATEGY = 2'd0;
   localparam logic [1:0] CSR_QUANTUM  = 2'd1;
   localparam logic [1:0] CSR_TICKETS  = 2'd2;

   localparam logic [2:0] PRIO_DEFAULT  = 3'd3;
   localparam logic [2:0] PRIO_FALLBACK = 3'd5;
   localparam logic [2:0] PRIO_WORST    = 3'd6;

   // Decoded request handed from the front end to the engine.
   typedef struct packed {
      logic [2:0]  op;
      logic [5:0]  entry;
      logic        bad_entry;
      logic        state_ok;
      logic [2:0]  new_state;
      logic [2:0]  new_prio;
      logic [15:0] winner;
   } cmd_type;

   // One task table entry.
   typedef struct packed {
      logic [2:0]  st;
      logic [2:0]  prio;
      logic [31:0] turnaround;
      logic [31:0] waiting;
      logic [31:0] burst;
      logic [7:0]  slice;
      logic [31:0] start_t;
      logic [31:0] end_t;
   } rec_type;

   localparam rec_type REC_RESET = '{st: ST_UNUSED, prio: PRIO_DEFAULT, default: '0};
   localparam rec_type REC_ZERO  = '0;

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   function automatic logic [2:0] map_prio(input logic [3:0] p);
      map_prio = (p >= 4'd1 && p <= 4'd6) ? p[2:0] : PRIO_FALLBACK;
   endfunction

   function automatic logic [7:0] table_slice(input logic [2:0] p);
      logic [7:0] s;
      unique case (p)
         3'd2:    s = 8'd15;
         3'd3:    s = 8'd12;
         3'd4:    s = 8'd8;
         3'd5:    s = 8'd6;
         3'd6:    s = 8'd4;
         default: s = 8'd2;
      endcase
      table_slice = s;
   endfunction

   // Accounting update of one entry for one tick.
   function automatic rec_type tick_rec(input rec_type r);
      rec_type n;
      n = r;
      if (r.st == ST_RUNNABLE) begin
         n.turnaround = sat_inc(r.turnaround);
         n.waiting    = sat_inc(r.waiting);
      end else if (r.st == ST_SLEEPING) begin
         n.turnaround = sat_inc(r.turnaround);
      end else if (r.st == ST_RUNNING) begin
         n.turnaround = sat_inc(r.turnaround);
         n.burst      = sat_inc(r.burst);
         if (r.slice != 8'd0) begin
            n.slice = r.slice - 8'd1;
         end
      end
      tick_rec = n;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/mpts_front.sv -----
`default_nettype none
module mpts_front (
   input  wire logic [2:0]       req_opcode,
   input  wire logic [5:0]       req_entry,
   input  wire logic [2:0]       req_new_state,
   input  wire logic [3:0]       req_new_priority,
   input  wire logic [15:0]      req_winner,
   output mpts_pkg::cmd_type     cmd
);

   // Classify the beat: range check, state check and priority mapping.
   always_comb begin
      cmd.op        = req_opcode;
      cmd.entry     = req_entry;
      cmd.bad_entry = (32'(req_entry) >= mpts_pkg::NUM_ENTRIES);
      cmd.state_ok  = (req_new_state <= mpts_pkg::ST_ZOMBIE);
      cmd.new_state = req_new_state;
      cmd.new_prio  = mpts_pkg::map_prio(req_new_priority);
      cmd.winner    = req_winner;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mpts_queue.sv -----
`default_nettype none
module mpts_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  mpts_pkg::cmd_type      push_cmd,
   output logic                   full,
   output logic                   pop_valid,
   output mpts_pkg::cmd_type      pop_cmd,
   input  wire logic              pop
);

   mpts_pkg::cmd_type slot_ff [2];
   logic [1:0]        count_ff;
   logic              wptr_ff;
   logic              rptr_ff;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_cmd   = slot_ff[rptr_ff];

   // Two-slot command queue between front end and engine.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
      end else begin
         if (push) begin
            slot_ff[wptr_ff] <= push_cmd;
            wptr_ff          <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/mpts_engine.sv -----
`default_nettype none
`include "multi_policy_task_scheduler_assert.svh"
module mpts_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  mpts_pkg::cmd_type      q_cmd,
   output logic                   q_pop,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [9:0]        csr_write_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_status,
   output logic [5:0]             rsp_chosen_entry,
   output mpts_pkg::rec_type      rsp_rec
);

   localparam int NUM_ENTRIES = mpts_pkg::NUM_ENTRIES;
   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
   localparam int TOT_W = 10 + CNT_W;
   localparam int LOT_W = (TOT_W > 16) ? TOT_W : 16;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_MODIFY, S_SCAN, S_END, S_MULT, S_FINISH
   } eng_state_type;

   eng_state_type      state_ff;
   mpts_pkg::cmd_type  cmd_ff;
   logic               phase2_ff;
   logic [CNT_W-1:0]   issue_cnt_ff;
   logic [IDX_W-1:0]   scan_addr_ff;
   logic               data_ok_ff;
   logic [IDX_W-1:0]   data_addr_ff;
   mpts_pkg::rec_type  rd_data_ff;
   logic               rd_vld_ff;
   logic [NUM_ENTRIES-1:0] vld_ff;
   mpts_pkg::rec_type  rec_mem [NUM_ENTRIES];
   logic               found_ff;
   logic [IDX_W-1:0]   sel_ff;
   mpts_pkg::rec_type  sel_rec_ff;
   logic [CNT_W-1:0]   any_cnt_ff;
   logic [2:0]         best_ff;
   logic [LOT_W-1:0]   total_ff;
   logic [LOT_W-1:0]   draw_ff;
   logic [LOT_W-1:0]   passed_ff;
   logic [IDX_W-1:0]   last_ff;
   logic [31:0]        tick_ff;
   logic [2:0]         strategy_ff;
   logic [7:0]         quantum_ff;
   logic [9:0]         tickets_ff;
   logic               fin_wr_ff;
   logic               res_status_ff;
   mpts_pkg::rec_type  res_rec_ff;
   logic               rsp_valid_ff;
   logic               rsp_status_ff;
   logic [5:0]         rsp_entry_ff;
   mpts_pkg::rec_type  rsp_rec_ff;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   mpts_pkg::rec_type  wr_data;
   mpts_pkg::rec_type  eff_rec;
   mpts_pkg::rec_type  mod_rec;
   mpts_pkg::rec_type  new_rec;
   mpts_pkg::rec_type  run_rec;
   logic [LOT_W-1:0]   passed_sum;
   logic               last_data;
   logic               runnable;
   logic               rsp_free;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_entry = rsp_entry_ff;
   assign rsp_rec          = rsp_rec_ff;

   assign q_pop      = (state_ff == S_IDLE) && q_valid;
   assign eff_rec    = rd_vld_ff ? rd_data_ff : mpts_pkg::REC_RESET;
   assign passed_sum = passed_ff + LOT_W'(tickets_ff);
   assign last_data  = data_ok_ff && (issue_cnt_ff == CNT_W'(NUM_ENTRIES));
   assign runnable   = (eff_rec.st == mpts_pkg::ST_RUNNABLE);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
      wrap_inc = (a == LAST_IDX) ? '0 : a + IDX_W'(1);
   endfunction

   // Entry update for set state and set priority.
   always_comb begin
      mod_rec = eff_rec;
      if (cmd_ff.op == mpts_pkg::OP_SET_STATE && cmd_ff.state_ok) begin
         mod_rec.st = cmd_ff.new_state;
         if (cmd_ff.new_state == mpts_pkg::ST_ZOMBIE) begin
            mod_rec.end_t = tick_ff;
         end
      end else if (cmd_ff.op == mpts_pkg::OP_SET_PRIO) begin
         mod_rec.prio = cmd_ff.new_prio;
      end
   end

   // Fresh entry for allocate and the picked entry made running.
   always_comb begin
      new_rec         = mpts_pkg::REC_ZERO;
      new_rec.st      = mpts_pkg::ST_EMBRYO;
      new_rec.prio    = mpts_pkg::PRIO_DEFAULT;
      new_rec.start_t = tick_ff;
      run_rec         = sel_rec_ff;
      run_rec.st      = mpts_pkg::ST_RUNNING;
      if (strategy_ff == mpts_pkg::STRAT_RR) begin
         run_rec.slice = 8'd1;
      end else if (strategy_ff == mpts_pkg::STRAT_PRIO_TBL) begin
         run_rec.slice = mpts_pkg::table_slice(sel_rec_ff.prio);
      end else begin
         run_rec.slice = quantum_ff;
      end
   end

   // Table port control.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_addr_ff;
      wr_en   = 1'b0;
      wr_addr = data_addr_ff;
      wr_data = mod_rec;
      unique case (state_ff)
         S_READ: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(cmd_ff.entry);
         end
         S_MODIFY: begin
            wr_en = (cmd_ff.op != mpts_pkg::OP_QUERY);
         end
         S_SCAN: begin
            rd_en = (issue_cnt_ff != CNT_W'(NUM_ENTRIES));
            if (cmd_ff.op == mpts_pkg::OP_TICK && data_ok_ff) begin
               wr_en   = 1'b1;
               wr_data = mpts_pkg::tick_rec(eff_rec);
            end
         end
         S_FINISH: begin
            wr_en   = fin_wr_ff;
            wr_addr = sel_ff;
            wr_data = res_rec_ff;
         end
         default: begin
         end
      endcase
   end

   // Task table: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rec_mem[wr_addr] <= wr_data;
      end
      rd_data_ff   <= rec_mem[rd_addr];
      data_addr_ff <= rd_addr;
   end

   // Per-entry valid bits; an entry never written reads as its reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         data_ok_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= vld_ff[rd_addr];
         data_ok_ff <= rd_en;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Sequencer, configuration registers and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase2_ff     <= 1'b0;
         found_ff      <= 1'b0;
         fin_wr_ff     <= 1'b0;
         last_ff       <= LAST_IDX;
         tick_ff       <= '0;
         strategy_ff   <= mpts_pkg::STRAT_RR;
         quantum_ff    <= 8'd5;
         tickets_ff    <= 10'd10;
         rsp_valid_ff  <= 1'b0;
         issue_cnt_ff  <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               mpts_pkg::CSR_STRATEGY: strategy_ff <= csr_write_data[2:0];
               mpts_pkg::CSR_QUANTUM:  quantum_ff  <= csr_write_data[7:0];
               mpts_pkg::CSR_TICKETS:  tickets_ff  <= csr_write_data;
               default: begin
               end
            endcase
         end
         // A taken result beat empties the register unless a new one loads.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff        <= q_cmd;
                  phase2_ff     <= 1'b0;
                  found_ff      <= 1'b0;
                  fin_wr_ff     <= 1'b0;
                  issue_cnt_ff  <= '0;
                  scan_addr_ff  <= '0;
                  any_cnt_ff    <= '0;
                  best_ff       <= mpts_pkg::PRIO_WORST;
                  sel_ff        <= '0;
                  res_rec_ff    <= mpts_pkg::REC_ZERO;
                  priority case (q_cmd.op)
                     mpts_pkg::OP_ALLOC, mpts_pkg::OP_TICK: begin
                        res_status_ff <= 1'b0;
                        state_ff      <= S_SCAN;
                     end
                     mpts_pkg::OP_SET_STATE, mpts_pkg::OP_SET_PRIO,
                     mpts_pkg::OP_QUERY: begin
                        res_status_ff <= q_cmd.bad_entry;
                        state_ff      <= q_cmd.bad_entry ? S_FINISH : S_READ;
                     end
                     mpts_pkg::OP_PICK: begin
                        res_status_ff <= (strategy_ff > mpts_pkg::STRAT_LOTTERY);
                        state_ff      <= (strategy_ff > mpts_pkg::STRAT_LOTTERY) ?
                                         S_FINISH : S_SCAN;
                     end
                     default: begin
                        res_status_ff <= 1'b0;
                        state_ff      <= S_FINISH;
                     end
                  endcase
               end
            end
            S_READ: begin
               state_ff <= S_MODIFY;
            end
            S_MODIFY: begin
               sel_ff     <= data_addr_ff;
               res_rec_ff <= mod_rec;
               state_ff   <= S_FINISH;
            end
            S_SCAN: begin
               if (rd_en) begin
                  scan_addr_ff <= wrap_inc(scan_addr_ff);
                  issue_cnt_ff <= issue_cnt_ff + CNT_W'(1);
               end
               if (data_ok_ff) begin
                  // Evaluate the entry whose data arrived this cycle.
                  if (cmd_ff.op == mpts_pkg::OP_ALLOC) begin
                     if (!found_ff && eff_rec.st == mpts_pkg::ST_UNUSED) begin
                        found_ff <= 1'b1;
                        sel_ff   <= data_addr_ff;
                     end
                  end else if (cmd_ff.op == mpts_pkg::OP_PICK && runnable) begin
                     if (!phase2_ff) begin
                        any_cnt_ff <= any_cnt_ff + CNT_W'(1);
                        if (eff_rec.prio < best_ff) begin
                           best_ff <= eff_rec.prio;
                        end
                     end else if (!found_ff) begin
                        if (strategy_ff == mpts_pkg::STRAT_LOTTERY) begin
                           passed_ff <= passed_sum;
                           if (passed_sum >= draw_ff) begin
                              found_ff   <= 1'b1;
                              sel_ff     <= data_addr_ff;
                              sel_rec_ff <= eff_rec;
                           end
                        end else if (strategy_ff < mpts_pkg::STRAT_PRIO_Q ||
                                     eff_rec.prio == best_ff) begin
                           found_ff   <= 1'b1;
                           sel_ff     <= data_addr_ff;
                           sel_rec_ff <= eff_rec;
                        end
                     end
                  end
               end
               if (last_data) begin
                  state_ff <= S_END;
               end
            end
            S_END: begin
               if (cmd_ff.op == mpts_pkg::OP_ALLOC) begin
                  res_status_ff <= !found_ff;
                  fin_wr_ff     <= found_ff;
                  res_rec_ff    <= found_ff ? new_rec : mpts_pkg::REC_ZERO;
                  state_ff      <= S_FINISH;
               end else if (cmd_ff.op == mpts_pkg::OP_TICK) begin
                  tick_ff  <= mpts_pkg::sat_inc(tick_ff);
                  state_ff <= S_FINISH;
               end else if (!phase2_ff) begin
                  // End of the first pick pass: size the lottery pool.
                  total_ff <= LOT_W'(any_cnt_ff) * LOT_W'(tickets_ff);
                  if (any_cnt_ff == '0) begin
                     res_status_ff <= 1'b1;
                     state_ff      <= S_FINISH;
                  end else begin
                     state_ff <= S_MULT;
                  end
               end else if (found_ff) begin
                  res_rec_ff <= run_rec;
                  fin_wr_ff  <= 1'b1;
                  last_ff    <= sel_ff;
                  state_ff   <= S_FINISH;
               end else begin
                  res_status_ff <= 1'b1;
                  sel_ff        <= '0;
                  state_ff      <= S_FINISH;
               end
            end
            S_MULT: begin
               // Clamp the draw and start the second pass.
               draw_ff      <= (LOT_W'(cmd_ff.winner) > total_ff) ?
                               total_ff : LOT_W'(cmd_ff.winner);
               passed_ff    <= '0;
               phase2_ff    <= 1'b1;
               found_ff     <= 1'b0;
               issue_cnt_ff <= '0;
               scan_addr_ff <= (strategy_ff == mpts_pkg::STRAT_LOTTERY) ?
                               '0 : wrap_inc(last_ff);
               state_ff     <= S_SCAN;
            end
            S_FINISH: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_entry_ff  <= res_status_ff ? 6'd0 : 6'(sel_ff);
                  rsp_rec_ff    <= res_rec_ff;
                  fin_wr_ff     <= 1'b0;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `MPTS_ASSERT_IMP(a_data_only_in_access, clock, reset, data_ok_ff, (state_ff == S_MODIFY) || (state_ff == S_SCAN))
   `MPTS_ASSERT_NEXT(a_tick_never_drops, clock, reset, 1'b1, tick_ff >= $past(tick_ff))
   `MPTS_ASSERT_IMP(a_write_in_table, clock, reset, wr_en, 32'(wr_addr) < NUM_ENTRIES)

endmodule
`default_nettype wire

// ----- hw/rtl/multi_policy_task_scheduler.sv -----
// Multi-policy task scheduler.
// Request channel (req_*): one operation per beat (allocate, set state, set
// priority, tick, pick, query). Result channel (rsp_*): exactly one beat per
// request, in request order. Both use valid/stall; a beat moves when valid is
// high and stall is low. csr_* writes strategy, quantum and ticket count and
// may only be used while the block is idle.
// Requests are decoded and placed in a two-deep queue, so the sender can run
// ahead while the engine works. The engine walks the task table, one entry
// per cycle through its one read port and one write port.
// Set state, set priority and query read the entry, then write it back (query
// does not write); an entry out of range or an unknown opcode goes straight to
// the result. Allocate and tick scan the table once; pick scans it once to find
// the runnable entries and, if there are any, a second time to choose one.
// The engine takes the next request only once it is through with the last.
// Reset empties the queue and result register and returns every entry to
// unused, priority 3, zero counters. While rsp_stall is high the result is
// held, the engine waits after its current item and the queue fills; req_stall
// rises when the queue is full.
`default_nettype none
module multi_policy_task_scheduler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [5:0]  req_entry,
   input  wire logic [2:0]  req_new_state,
   input  wire logic [3:0]  req_new_priority,
   input  wire logic [15:0] req_winner,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_status,
   output logic [5:0]       rsp_chosen_entry,
   output logic [7:0]       rsp_slice,
   output logic [2:0]       rsp_entry_priority,
   output logic [31:0]      rsp_turnaround_ticks,
   output logic [31:0]      rsp_waiting_ticks,
   output logic [31:0]      rsp_burst_ticks,
   output logic [31:0]      rsp_start_tick,
   output logic [31:0]      rsp_end_tick,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_write_data
);

   mpts_pkg::cmd_type front_cmd;
   mpts_pkg::cmd_type q_cmd;
   mpts_pkg::rec_type out_rec;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;

   assign req_stall = q_full;

   mpts_front u_front (
      .req_opcode       (req_opcode),
      .req_entry        (req_entry),
      .req_new_state    (req_new_state),
      .req_new_priority (req_new_priority),
      .req_winner       (req_winner),
      .cmd              (front_cmd)
   );

   mpts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_cmd   (q_cmd),
      .pop       (q_pop)
   );

   mpts_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_chosen_entry (rsp_chosen_entry),
      .rsp_rec          (out_rec)
   );

   // Unpack the result entry onto the result ports.
   assign rsp_slice            = out_rec.slice;
   assign rsp_entry_priority   = out_rec.prio;
   assign rsp_turnaround_ticks = out_rec.turnaround;
   assign rsp_waiting_ticks    = out_rec.waiting;
   assign rsp_burst_ticks      = out_rec.burst;
   assign rsp_start_tick       = out_rec.start_t;
   assign rsp_end_tick         = out_rec.end_t;

endmodule
`default_nettype wire
